// ===== design/sorted_event_queue_top_macros.svh =====
// assertion macros shared by the checker of the event queue
`ifndef SORTED_EVENT_QUEUE_TOP_MACROS_SVH
`define SORTED_EVENT_QUEUE_TOP_MACROS_SVH

// checked only outside reset
`define SEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define SEQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sorq_pkg.sv =====
// types and constants of the sorted event queue
`timescale 1ns / 1ps

package sorq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int ARR_W       = 32;
  localparam int DLY_W       = 16;
  localparam int LEN_W       = 5;
  localparam int IN_W        = 72;
  localparam int OUT_W       = 72;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_APPEND = 2'd1,
    FN_POP    = 2'd2,
    FN_TICK   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_TICK   = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [ARR_W-1:0] arrival;
    logic [DLY_W-1:0] delay;
  } entry_t;

  typedef struct packed {
    cell_op_t op;
    logic     append;
  } cell_ctrl_t;

endpackage

// ===== design/sorq_cell.sv =====
// one slot of the queue: holds an entry and shifts with its neighbors
`timescale 1ns / 1ps

module sorq_cell (
  input  logic                clk,
  input  sorq_pkg::cell_ctrl_t ctrl,
  input  sorq_pkg::entry_t    new_entry,
  input  sorq_pkg::entry_t    left,
  input  sorq_pkg::entry_t    right,
  input  logic                occ,
  input  logic                pass_in,
  output logic                pass_out,
  output sorq_pkg::entry_t    q
);
  import sorq_pkg::*;

  entry_t q_next;
  logic   gt;

  // new item goes behind this slot
  assign gt       = occ && (ctrl.append || (new_entry.arrival > q.arrival));
  assign pass_out = pass_in && gt;

  always_comb begin
    q_next = q;
    case (ctrl.op)
      CELL_INSERT: begin
        if (!pass_in) begin
          q_next = left;
        end else if (!gt) begin
          q_next = new_entry;
        end
      end
      CELL_POP: begin
        q_next = right;
      end
      CELL_TICK: begin
        if (q.delay != '0) begin
          q_next.delay = q.delay - DLY_W'(1);
        end
      end
      default: begin
        q_next = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

// ===== design/sorted_event_queue_top.sv =====
// top level of the sorted event queue
`timescale 1ns / 1ps

// Bounded event queue of QUEUE_DEPTH entries (packet id, arrival time, delay)
// kept in a row of slots that shift in place. It takes one item per clock
// cycle and gives its result in the cycle after acceptance through an output
// register; an item is accepted whenever that register is empty or being
// read. Insert places the entry before the first slot whose arrival time is
// not smaller, append at the tail, pop returns the head, tick lowers every
// nonzero delay by one. The insert position is found by a compare chain
// that runs through all slots within the cycle, which sets the clock limit.

module sorted_event_queue_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // func, packet_id, arrival_time, delay_ticks, zero fill
  input  logic [sorq_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_packet_id, out_arrival, out_delay, head_expired, queue_length, status
  output logic [sorq_pkg::OUT_W-1:0] m_axis_tdata
);
  import sorq_pkg::*;

  func_t             func;
  entry_t            new_entry;
  cell_ctrl_t        ctrl;
  entry_t            cell_q [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   pass;
  logic [QUEUE_DEPTH-1:0] occ;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W+LEN_W-1:0] count_ext;
  logic              take;
  logic              full;
  logic              empty;
  entry_t            res_entry;
  logic              res_exp;
  status_t           res_status;

  assign func      = func_t'(s_axis_tdata[1:0]);
  assign new_entry.id      = s_axis_tdata[17:2];
  assign new_entry.arrival = s_axis_tdata[49:18];
  assign new_entry.delay   = s_axis_tdata[65:50];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign full          = (count == CNT_W'(QUEUE_DEPTH));
  assign empty         = (count == '0);

  always_comb begin
    ctrl.op     = CELL_HOLD;
    ctrl.append = (func == FN_APPEND);
    count_next  = count;
    res_entry   = '0;
    res_exp     = 1'b0;
    res_status  = ST_OK;
    case (func)
      FN_INSERT, FN_APPEND: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          ctrl.op    = take ? CELL_INSERT : CELL_HOLD;
          count_next = count + CNT_W'(1);
        end
      end
      FN_POP: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          ctrl.op    = take ? CELL_POP : CELL_HOLD;
          count_next = count - CNT_W'(1);
          res_entry  = cell_q[0];
        end
      end
      FN_TICK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          ctrl.op = take ? CELL_TICK : CELL_HOLD;
          res_exp = (cell_q[0].delay <= DLY_W'(1));
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  assign count_ext = {{LEN_W{1'b0}}, count_next};
  assign pass[0]   = 1'b1;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left;
    entry_t right;

    assign occ[i] = (count > CNT_W'(i));

    if (i == 0) begin : g_first
      assign left = new_entry;
    end else begin : g_inner_l
      assign left = cell_q[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = cell_q[i];
    end else begin : g_inner_r
      assign right = cell_q[i+1];
    end

    sorq_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .new_entry(new_entry),
      .left     (left),
      .right    (right),
      .occ      (occ[i]),
      .pass_in  (pass[i]),
      .pass_out (pass[i+1]),
      .q        (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (take) begin
        count <= count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= {res_status, count_ext[LEN_W-1:0], res_exp, res_entry.delay,
                       res_entry.arrival, res_entry.id};
    end
  end

endmodule

// ===== design/sorq_checker.sv =====
// port-level checks of the sorted event queue
`timescale 1ns / 1ps
`include "sorted_event_queue_top_macros.svh"

module sorq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  import sorq_pkg::*;

  `SEQ_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid, "output valid after reset")
  `SEQ_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `SEQ_ASSERT(a_ready, !m_axis_tvalid |-> s_axis_tready, "not ready with empty output")
  `SEQ_ASSERT(a_empty_len, m_axis_tvalid && m_axis_tdata[71:70] == ST_EMPTY |-> m_axis_tdata[69:65] == 5'd0 && m_axis_tdata[15:0] == 16'd0, "empty result not clean")
  `SEQ_ASSERT(a_exp_ok, m_axis_tvalid && m_axis_tdata[64] |-> m_axis_tdata[71:70] == ST_OK, "expired flag on failed op")

endmodule

bind sorted_event_queue_top sorq_checker u_sorq_checker (.*);

// ===== sim/testbench.sv =====
// testbench of the sorted event queue: random and directed items against a shadow queue
`timescale 1ns / 1ps

module testbench;
  import sorq_pkg::*;

  localparam int NUM_RANDOM  = 1100;
  localparam int CALM_TAIL   = 150;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [5:0]       fill;
    logic [DLY_W-1:0] delay;
    logic [ARR_W-1:0] arrival;
    logic [ID_W-1:0]  id;
    func_t            func;
  } op_word_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] length;
    logic             expired;
    logic [DLY_W-1:0] delay;
    logic [ARR_W-1:0] arrival;
    logic [ID_W-1:0]  id;
  } result_t;

  typedef struct {
    bit       sync;
    op_word_t op;
  } pending_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  pending_t pending_ops[$];
  result_t  predicted_results[$];
  entry_t   shadow_slots[QUEUE_DEPTH];
  int       shadow_count = 0;
  int       errors = 0;
  int       accepted_items = 0;
  int       cycles = 0;

  sorted_event_queue_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the slot row, updated once per accepted item
  function automatic result_t predict_queue_op(op_word_t op);
    result_t r;
    int      pos;
    int      k;
    r = '0;
    r.status = ST_OK;
    case (op.func)
      FN_INSERT, FN_APPEND: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = shadow_count;
          if (op.func == FN_INSERT) begin
            pos = 0;
            while (pos < shadow_count && op.arrival > shadow_slots[pos].arrival) pos++;
          end
          for (k = shadow_count; k > pos; k--) shadow_slots[k] = shadow_slots[k-1];
          shadow_slots[pos].id      = op.id;
          shadow_slots[pos].arrival = op.arrival;
          shadow_slots[pos].delay   = op.delay;
          shadow_count++;
        end
      end
      FN_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.id      = shadow_slots[0].id;
          r.arrival = shadow_slots[0].arrival;
          r.delay   = shadow_slots[0].delay;
          for (k = 1; k < shadow_count; k++) shadow_slots[k-1] = shadow_slots[k];
          shadow_count--;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (k = 0; k < shadow_count; k++) begin
            if (shadow_slots[k].delay != '0) shadow_slots[k].delay = shadow_slots[k].delay - 1'b1;
          end
          r.expired = (shadow_slots[0].delay == '0);
        end
      end
    endcase
    r.length = LEN_W'(shadow_count);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic add_op(func_t func, logic [ID_W-1:0] id, logic [ARR_W-1:0] arrival,
                        logic [DLY_W-1:0] delay);
    pending_t p;
    p.sync = 1'b0;
    p.op = '{fill: '0, delay: delay, arrival: arrival, id: id, func: func};
    pending_ops.push_back(p);
  endtask

  task automatic add_sync();
    pending_t p;
    p.sync = 1'b1;
    p.op = '0;
    pending_ops.push_back(p);
  endtask

  function automatic logic [ARR_W-1:0] pick_arrival();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return ARR_W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DLY_W-1:0] pick_delay();
    case ($urandom_range(0, 7))
      0: return '1;
      1, 2: return DLY_W'($urandom_range(0, 65535));
      default: return DLY_W'($urandom_range(0, 3));
    endcase
  endfunction

  // sender: offers pending items, honors sync points and random gaps
  pending_t next_item;
  op_word_t on_bus;
  logic     offer;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap_left = 0;
    end else begin
      offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predicted_results.push_back(predict_queue_op(on_bus));
        accepted_items++;
        offer = 1'b0;
        if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
          gap_left = $urandom_range(1, 5);
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          while (pending_ops.size() > 0 && pending_ops[0].sync && predicted_results.size() == 0)
            void'(pending_ops.pop_front());
          if (pending_ops.size() > 0 && !pending_ops[0].sync) begin
            next_item = pending_ops.pop_front();
            on_bus = next_item.op;
            offer = 1'b1;
          end
        end
      end
      s_axis_tvalid <= offer;
      s_axis_tdata  <= on_bus;
    end
  end

  // receiver: random stalls plus one long hold to back the queue up
  int  hold_left = 0;
  int  stall_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (!long_hold_done && accepted_items >= 400) begin
        long_hold_done = 1'b1;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (pending_ops.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker
  result_t got;
  result_t want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = predicted_results.pop_front();
        check_field("out_packet_id", want.id, got.id);
        check_field("out_arrival", want.arrival, got.arrival);
        check_field("out_delay", want.delay, got.delay);
        check_field("head_expired", want.expired, got.expired);
        check_field("queue_length", want.length, got.length);
        check_field("status", want.status, got.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_event_queue_top regression: fail");
      $finish;
    end
  end

  int depth_est;
  int made;
  int n;
  int k;

  initial begin
    // empty queue, extremes, equal keys, unsorted append, expiry
    add_op(FN_POP, '0, '0, '0);
    add_op(FN_TICK, '1, '1, '1);
    add_op(FN_INSERT, '1, '1, 16'd1);
    add_op(FN_INSERT, '0, '0, '0);
    add_op(FN_INSERT, 16'd1, '0, 16'd2);
    add_op(FN_APPEND, 16'd2, 32'd5, '1);
    add_op(FN_INSERT, 16'd3, 32'd6, 16'd0);
    add_op(FN_TICK, '0, '0, '0);
    add_op(FN_POP, '0, '0, '0);
    add_op(FN_TICK, '0, '0, '0);
    for (k = 0; k < 5; k++) add_op(FN_POP, '0, '0, '0);
    add_op(FN_TICK, '0, '0, '0);
    add_sync();

    depth_est = 0;
    made = 0;
    while (made < NUM_RANDOM) begin
      case ($urandom_range(0, 3))
        0: begin
          n = QUEUE_DEPTH - depth_est + $urandom_range(0, 3);
          for (k = 0; k < n; k++) begin
            add_op(func_t'($urandom_range(0, 4) == 0 ? FN_APPEND : FN_INSERT),
                   ID_W'($urandom), pick_arrival(), pick_delay());
            if (depth_est < QUEUE_DEPTH) depth_est++;
          end
        end
        1: begin
          n = depth_est + $urandom_range(0, 2);
          for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0) begin
              add_op(FN_TICK, ID_W'($urandom), $urandom, DLY_W'($urandom));
            end else begin
              add_op(FN_POP, ID_W'($urandom), $urandom, DLY_W'($urandom));
              if (depth_est > 0) depth_est--;
            end
          end
        end
        2: begin
          n = 20;
          for (k = 0; k < n; k++) begin
            add_op(func_t'($urandom_range(0, 3)), ID_W'($urandom), pick_arrival(), pick_delay());
            case (pending_ops[$].op.func)
              FN_INSERT, FN_APPEND: if (depth_est < QUEUE_DEPTH) depth_est++;
              FN_POP: if (depth_est > 0) depth_est--;
              default: ;
            endcase
          end
        end
        default: begin
          n = $urandom_range(2, 6);
          for (k = 0; k < n; k++) add_op(FN_TICK, ID_W'($urandom), $urandom, DLY_W'($urandom));
        end
      endcase
      made += n;
      if (made % 300 < n) add_sync();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    wait (pending_ops.size() == 0 && !s_axis_tvalid && predicted_results.size() == 0);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("sorted_event_queue_top regression: pass");
    end else begin
      $display("sorted_event_queue_top regression: fail");
    end
    $finish;
  end

endmodule
